// ===== src/csb_pkg.sv =====
// Shared widths, limits, register indexes and pipeline word types for the
// clipped alpha sprite blitter. No dependencies.
package csb_pkg;

    localparam int CH_W    = 8;
    localparam int IDX_W   = 24;
    localparam int DIM_W   = 13;
    localparam int CNT_W   = 12;
    localparam int POS_W   = DIM_W + 1;
    localparam int SUM_W   = 2 * CH_W;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int MAX_DIM = 4096;

    localparam logic [CH_W-1:0] ALPHA_OPAQUE = '1;
    localparam logic [CH_W-1:0] ALPHA_CLEAR  = '0;

    typedef enum logic [2:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_SPRITE_WIDTH  = 3'd2,
        REG_SPRITE_HEIGHT = 3'd3,
        REG_POS_X         = 3'd4,
        REG_POS_Y         = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [CH_W-1:0]  tex_red;
        logic [CH_W-1:0]  tex_green;
        logic [CH_W-1:0]  tex_blue;
        logic [CH_W-1:0]  tex_alpha;
        logic [CH_W-1:0]  dst_red;
        logic [CH_W-1:0]  dst_green;
        logic [CH_W-1:0]  dst_blue;
        logic [POS_W-1:0] sx;
        logic [POS_W-1:0] sy;
        logic             last;
    } a_stage_t;

    typedef struct packed {
        logic             on_screen;
        logic             opaque;
        logic             clear;
        logic [CH_W-1:0]  tex_red;
        logic [CH_W-1:0]  tex_green;
        logic [CH_W-1:0]  tex_blue;
        logic [SUM_W-1:0] sum_red;
        logic [SUM_W-1:0] sum_green;
        logic [SUM_W-1:0] sum_blue;
        logic [CNT_W-1:0] column;
        logic [IDX_W-1:0] row_offset;
        logic             last;
    } b_stage_t;

    typedef struct packed {
        logic             write_pixel;
        logic             write_alpha;
        logic [IDX_W-1:0] pixel_index;
        logic [CH_W-1:0]  out_red;
        logic [CH_W-1:0]  out_green;
        logic [CH_W-1:0]  out_blue;
        logic [CH_W-1:0]  out_alpha;
        logic             last_texel;
    } result_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_W'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

endpackage

// ===== src/csb_if.sv =====
// Valid/ready channels for texel words in and result words out.
// Depends on csb_pkg for field widths.
interface csb_texel_if;
    logic                      valid;
    logic                      ready;
    logic [csb_pkg::CH_W-1:0]  tex_red;
    logic [csb_pkg::CH_W-1:0]  tex_green;
    logic [csb_pkg::CH_W-1:0]  tex_blue;
    logic [csb_pkg::CH_W-1:0]  tex_alpha;
    logic [csb_pkg::CH_W-1:0]  dst_red;
    logic [csb_pkg::CH_W-1:0]  dst_green;
    logic [csb_pkg::CH_W-1:0]  dst_blue;

    modport source (
        output valid, tex_red, tex_green, tex_blue, tex_alpha,
               dst_red, dst_green, dst_blue,
        input  ready
    );
    modport sink (
        input  valid, tex_red, tex_green, tex_blue, tex_alpha,
               dst_red, dst_green, dst_blue,
        output ready
    );
endinterface

interface csb_result_if;
    logic                      valid;
    logic                      ready;
    logic                      write_pixel;
    logic                      write_alpha;
    logic [csb_pkg::IDX_W-1:0] pixel_index;
    logic [csb_pkg::CH_W-1:0]  out_red;
    logic [csb_pkg::CH_W-1:0]  out_green;
    logic [csb_pkg::CH_W-1:0]  out_blue;
    logic [csb_pkg::CH_W-1:0]  out_alpha;
    logic                      last_texel;

    modport source (
        output valid, write_pixel, write_alpha, pixel_index,
               out_red, out_green, out_blue, out_alpha, last_texel,
        input  ready
    );
    modport sink (
        input  valid, write_pixel, write_alpha, pixel_index,
               out_red, out_green, out_blue, out_alpha, last_texel,
        output ready
    );
endinterface

// ===== src/clipped_alpha_sprite_blit_core.sv =====
// Clipped alpha sprite blitter: top level with register file and pipeline.
// Depends on csb_pkg and the channel interfaces in csb_if.sv.
//
// Usage:
//   Texel words arrive on the texel channel in sprite raster order, each
//   with the screen colour currently at its destination. One result word
//   per texel leaves on the result channel: the screen index, the colour to
//   write and the write flags, with last_texel on the final texel.
//   Column and row counters wrap at the end of the sprite.
//   Set screen size, sprite size and position through the APB port while
//   the pipeline is empty; pready is always high and reads return the
//   stored register value.
//   A texel word moves through the A, B and output registers in turn.
//   Throughput: one texel per cycle while the receiver keeps up, set by the
//   three-stage pipeline (capture and position, clip and products, divide
//   by 255 and index add). When the receiver stalls, the whole pipeline
//   holds and texel ready drops until the result word is taken.
//   Reset: counters to zero, registers to their defaults, pipeline empty.
module clipped_alpha_sprite_blit_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [csb_pkg::ADDR_W-1:0]   paddr,
    input  logic [csb_pkg::DATA_W-1:0]   pwdata,
    output logic [csb_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    csb_texel_if.sink                    texel,
    csb_result_if.source                 result
);

    localparam int CH_W  = csb_pkg::CH_W;
    localparam int SUM_W = csb_pkg::SUM_W;
    localparam int DIM_W = csb_pkg::DIM_W;
    localparam int CNT_W = csb_pkg::CNT_W;
    localparam int IDX_W = csb_pkg::IDX_W;
    localparam int POS_W = csb_pkg::POS_W;

    function automatic logic [CH_W-1:0] div255(input logic [SUM_W-1:0] x);
        logic [SUM_W:0] t;
        t = {1'b0, x} + (SUM_W+1)'(1) + (SUM_W+1)'(x >> CH_W);
        return t[SUM_W-1:CH_W];
    endfunction

    logic [DIM_W-1:0] screen_width_reg;
    logic [DIM_W-1:0] screen_height_reg;
    logic [DIM_W-1:0] sprite_width_reg;
    logic [DIM_W-1:0] sprite_height_reg;
    logic [DIM_W-1:0] pos_x_reg;
    logic [DIM_W-1:0] pos_y_reg;

    logic cfg_write;
    csb_pkg::reg_idx_t cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = csb_pkg::reg_idx_t'(paddr[csb_pkg::ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= DIM_W'(1024);
            screen_height_reg <= DIM_W'(768);
            sprite_width_reg  <= DIM_W'(64);
            sprite_height_reg <= DIM_W'(64);
            pos_x_reg         <= '0;
            pos_y_reg         <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                csb_pkg::REG_SCREEN_WIDTH:  screen_width_reg  <= pwdata[DIM_W-1:0];
                csb_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= pwdata[DIM_W-1:0];
                csb_pkg::REG_SPRITE_WIDTH:  sprite_width_reg  <= pwdata[DIM_W-1:0];
                csb_pkg::REG_SPRITE_HEIGHT: sprite_height_reg <= pwdata[DIM_W-1:0];
                csb_pkg::REG_POS_X:         pos_x_reg         <= pwdata[DIM_W-1:0];
                csb_pkg::REG_POS_Y:         pos_y_reg         <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            csb_pkg::REG_SCREEN_WIDTH:  prdata = csb_pkg::DATA_W'(screen_width_reg);
            csb_pkg::REG_SCREEN_HEIGHT: prdata = csb_pkg::DATA_W'(screen_height_reg);
            csb_pkg::REG_SPRITE_WIDTH:  prdata = csb_pkg::DATA_W'(sprite_width_reg);
            csb_pkg::REG_SPRITE_HEIGHT: prdata = csb_pkg::DATA_W'(sprite_height_reg);
            csb_pkg::REG_POS_X:         prdata = csb_pkg::DATA_W'(pos_x_reg);
            csb_pkg::REG_POS_Y:         prdata = csb_pkg::DATA_W'(pos_y_reg);
            default:                    prdata = '0;
        endcase
    end

    logic [DIM_W-1:0] sw_eff, sh_eff, tw_eff, th_eff;
    logic [CNT_W-1:0] tw_last, th_last;

    assign sw_eff  = csb_pkg::clamp_dim(screen_width_reg);
    assign sh_eff  = csb_pkg::clamp_dim(screen_height_reg);
    assign tw_eff  = csb_pkg::clamp_dim(sprite_width_reg);
    assign th_eff  = csb_pkg::clamp_dim(sprite_height_reg);
    assign tw_last = CNT_W'(tw_eff - DIM_W'(1));
    assign th_last = CNT_W'(th_eff - DIM_W'(1));

    logic advance, take;
    logic a_valid_reg, b_valid_reg, out_valid_reg;
    csb_pkg::a_stage_t a_reg, a_next;
    csb_pkg::b_stage_t b_reg, b_next;
    csb_pkg::result_t  out_reg, out_next;

    logic [CNT_W-1:0] col_reg, row_reg, col_next, row_next;
    logic row_end, col_end;

    assign advance     = !out_valid_reg || result.ready;
    assign texel.ready = advance;
    assign take        = texel.valid && advance;

    assign row_end = col_reg >= tw_last;
    assign col_end = row_reg >= th_last;

    always_comb
    begin
        col_next = col_reg + CNT_W'(1);
        row_next = row_reg;
        if (row_end)
        begin
            col_next = '0;
            row_next = col_end ? '0 : row_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (take)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_comb
    begin
        a_next.tex_red   = texel.tex_red;
        a_next.tex_green = texel.tex_green;
        a_next.tex_blue  = texel.tex_blue;
        a_next.tex_alpha = texel.tex_alpha;
        a_next.dst_red   = texel.dst_red;
        a_next.dst_green = texel.dst_green;
        a_next.dst_blue  = texel.dst_blue;
        a_next.sx        = {pos_x_reg[DIM_W-1], pos_x_reg} + {2'b00, col_reg};
        a_next.sy        = {pos_y_reg[DIM_W-1], pos_y_reg} + {2'b00, row_reg};
        a_next.last      = row_end && col_end;
    end

    always_comb
    begin
        logic [CH_W-1:0] inv;
        inv = ~a_reg.tex_alpha;
        b_next.on_screen  = !a_reg.sx[POS_W-1] && (a_reg.sx[DIM_W-1:0] < sw_eff)
                         && !a_reg.sy[POS_W-1] && (a_reg.sy[DIM_W-1:0] < sh_eff);
        b_next.opaque     = a_reg.tex_alpha == csb_pkg::ALPHA_OPAQUE;
        b_next.clear      = a_reg.tex_alpha == csb_pkg::ALPHA_CLEAR;
        b_next.tex_red    = a_reg.tex_red;
        b_next.tex_green  = a_reg.tex_green;
        b_next.tex_blue   = a_reg.tex_blue;
        b_next.sum_red    = a_reg.tex_alpha * a_reg.tex_red   + inv * a_reg.dst_red;
        b_next.sum_green  = a_reg.tex_alpha * a_reg.tex_green + inv * a_reg.dst_green;
        b_next.sum_blue   = a_reg.tex_alpha * a_reg.tex_blue  + inv * a_reg.dst_blue;
        b_next.column     = a_reg.sx[CNT_W-1:0];
        b_next.row_offset = IDX_W'(a_reg.sy[CNT_W-1:0]) * IDX_W'(sw_eff);
        b_next.last       = a_reg.last;
    end

    always_comb
    begin
        out_next             = '0;
        out_next.last_texel  = b_reg.last;
        if (b_reg.on_screen)
        begin
            out_next.pixel_index = IDX_W'(b_reg.column) + b_reg.row_offset;
            if (b_reg.opaque)
            begin
                out_next.write_pixel = 1'b1;
                out_next.write_alpha = 1'b1;
                out_next.out_red     = b_reg.tex_red;
                out_next.out_green   = b_reg.tex_green;
                out_next.out_blue    = b_reg.tex_blue;
                out_next.out_alpha   = csb_pkg::ALPHA_OPAQUE;
            end
            else if (!b_reg.clear)
            begin
                out_next.write_pixel = 1'b1;
                out_next.out_red     = div255(b_reg.sum_red);
                out_next.out_green   = div255(b_reg.sum_green);
                out_next.out_blue    = div255(b_reg.sum_blue);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg   <= texel.valid;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            out_reg <= out_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.write_pixel = out_reg.write_pixel;
    assign result.write_alpha = out_reg.write_alpha;
    assign result.pixel_index = out_reg.pixel_index;
    assign result.out_red     = out_reg.out_red;
    assign result.out_green   = out_reg.out_green;
    assign result.out_blue    = out_reg.out_blue;
    assign result.out_alpha   = out_reg.out_alpha;
    assign result.last_texel  = out_reg.last_texel;

    a_opaque_flags: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.write_alpha |->
            result.write_pixel && result.out_alpha == csb_pkg::ALPHA_OPAQUE)
        else $error("alpha write without opaque pixel write");

    a_idle_colour: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.write_pixel |->
            result.out_red == '0 && result.out_green == '0 && result.out_blue == '0
            && result.out_alpha == '0)
        else $error("colour set on a skipped texel");

    a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        take && row_end |=> col_reg == '0)
        else $error("column counter did not wrap at row end");

    a_pipe_move: assert property (@(posedge clk) disable iff (!rst_n)
        advance && a_valid_reg |=> b_valid_reg)
        else $error("word lost between capture and product stages");

    a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(a_valid_reg) && $stable(b_valid_reg) && out_valid_reg)
        else $error("pipeline moved during a stall");

endmodule

// ===== dv/clipped_alpha_sprite_blit_core_tb.sv =====
// Testbench for clipped_alpha_sprite_blit_core: directed and random texel
// streams against a local blend and clip predictor, with APB register setup.
// Depends on csb_pkg, csb_if.sv and the core RTL.
module clipped_alpha_sprite_blit_core_tb;

    localparam int CH_W    = csb_pkg::CH_W;
    localparam int ADDR_W  = csb_pkg::ADDR_W;
    localparam int DATA_W  = csb_pkg::DATA_W;
    localparam int DIM_W   = csb_pkg::DIM_W;
    localparam int CNT_W   = csb_pkg::CNT_W;
    localparam int IDX_W   = csb_pkg::IDX_W;
    localparam int MAX_DIM = csb_pkg::MAX_DIM;

    localparam int UNMAPPED_IDX_A = 6;
    localparam int UNMAPPED_IDX_B = 7;

    typedef csb_pkg::result_t result_t;

    typedef struct packed {
        logic [CH_W-1:0] tex_red;
        logic [CH_W-1:0] tex_green;
        logic [CH_W-1:0] tex_blue;
        logic [CH_W-1:0] tex_alpha;
        logic [CH_W-1:0] dst_red;
        logic [CH_W-1:0] dst_green;
        logic [CH_W-1:0] dst_blue;
    } texel_word_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    csb_texel_if  texel_bus ();
    csb_result_if result_bus ();

    clipped_alpha_sprite_blit_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .texel   (texel_bus),
        .result  (result_bus)
    );

    logic [DIM_W-1:0] scr_w   = DIM_W'(1024);
    logic [DIM_W-1:0] scr_h   = DIM_W'(768);
    logic [DIM_W-1:0] spr_w   = DIM_W'(64);
    logic [DIM_W-1:0] spr_h   = DIM_W'(64);
    logic [DIM_W-1:0] org_x   = '0;
    logic [DIM_W-1:0] org_y   = '0;
    logic [CNT_W-1:0] tex_col = '0;
    logic [CNT_W-1:0] tex_row = '0;

    result_t pending_pixels[$];
    int      mismatch_count = 0;
    bit      calm = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic int eff_dim(input logic [DIM_W-1:0] v);
        if (v == '0)
        begin
            return 1;
        end
        if (v > DIM_W'(MAX_DIM))
        begin
            return MAX_DIM;
        end
        return int'(v);
    endfunction

    function automatic logic [CH_W-1:0] mix_channel(input int a, input int t, input int d);
        return CH_W'((a * t + (255 - a) * d) / 255);
    endfunction

    // Predict the word for one texel and advance the raster counters.
    function automatic result_t blend_pixel(input texel_word_t w);
        result_t r;
        int      sw;
        int      sh;
        int      tw;
        int      th;
        int      sx;
        int      sy;
        int      idx;
        bit      row_end;
        bit      col_end;
        r  = '0;
        sw = eff_dim(scr_w);
        sh = eff_dim(scr_h);
        tw = eff_dim(spr_w);
        th = eff_dim(spr_h);
        sx = $signed(org_x);
        sx = sx + int'(tex_col);
        sy = $signed(org_y);
        sy = sy + int'(tex_row);
        row_end = int'(tex_col) >= tw - 1;
        col_end = int'(tex_row) >= th - 1;
        if (sx >= 0 && sx < sw && sy >= 0 && sy < sh)
        begin
            idx = sx + sy * sw;
            r.pixel_index = IDX_W'(idx);
            if (w.tex_alpha == csb_pkg::ALPHA_OPAQUE)
            begin
                r.write_pixel = 1'b1;
                r.write_alpha = 1'b1;
                r.out_red     = w.tex_red;
                r.out_green   = w.tex_green;
                r.out_blue    = w.tex_blue;
                r.out_alpha   = csb_pkg::ALPHA_OPAQUE;
            end
            else if (w.tex_alpha != csb_pkg::ALPHA_CLEAR)
            begin
                r.write_pixel = 1'b1;
                r.out_red   = mix_channel(w.tex_alpha, w.tex_red, w.dst_red);
                r.out_green = mix_channel(w.tex_alpha, w.tex_green, w.dst_green);
                r.out_blue  = mix_channel(w.tex_alpha, w.tex_blue, w.dst_blue);
            end
        end
        r.last_texel = row_end && col_end;
        if (row_end)
        begin
            tex_col = '0;
            tex_row = col_end ? '0 : tex_row + 1'b1;
        end
        else
        begin
            tex_col = tex_col + 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h, want %0h at %0t", field, got, want, $time);
        mismatch_count++;
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && stall_left == 0 && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 7);
            end
            if (calm)
            begin
                stall_left = 0;
            end
            if (stall_left > 0)
            begin
                result_bus.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
        begin
            if (pending_pixels.size() == 0)
            begin
                report_mismatch("word with nothing pending", 1, 0);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (result_bus.write_pixel !== want.write_pixel)
                    report_mismatch("write_pixel", result_bus.write_pixel, want.write_pixel);
                if (result_bus.write_alpha !== want.write_alpha)
                    report_mismatch("write_alpha", result_bus.write_alpha, want.write_alpha);
                if (result_bus.pixel_index !== want.pixel_index)
                    report_mismatch("pixel_index", result_bus.pixel_index, want.pixel_index);
                if (result_bus.out_red !== want.out_red)
                    report_mismatch("out_red", result_bus.out_red, want.out_red);
                if (result_bus.out_green !== want.out_green)
                    report_mismatch("out_green", result_bus.out_green, want.out_green);
                if (result_bus.out_blue !== want.out_blue)
                    report_mismatch("out_blue", result_bus.out_blue, want.out_blue);
                if (result_bus.out_alpha !== want.out_alpha)
                    report_mismatch("out_alpha", result_bus.out_alpha, want.out_alpha);
                if (result_bus.last_texel !== want.last_texel)
                    report_mismatch("last_texel", result_bus.last_texel, want.last_texel);
            end
        end
    end

    task automatic write_reg(input int idx, input logic [DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        case (idx)
            csb_pkg::REG_SCREEN_WIDTH:  scr_w = value[DIM_W-1:0];
            csb_pkg::REG_SCREEN_HEIGHT: scr_h = value[DIM_W-1:0];
            csb_pkg::REG_SPRITE_WIDTH:  spr_w = value[DIM_W-1:0];
            csb_pkg::REG_SPRITE_HEIGHT: spr_h = value[DIM_W-1:0];
            csb_pkg::REG_POS_X:         org_x = value[DIM_W-1:0];
            csb_pkg::REG_POS_Y:         org_y = value[DIM_W-1:0];
            default:                    ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_texel(input texel_word_t w);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            texel_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        texel_bus.valid     <= 1'b1;
        texel_bus.tex_red   <= w.tex_red;
        texel_bus.tex_green <= w.tex_green;
        texel_bus.tex_blue  <= w.tex_blue;
        texel_bus.tex_alpha <= w.tex_alpha;
        texel_bus.dst_red   <= w.dst_red;
        texel_bus.dst_green <= w.dst_green;
        texel_bus.dst_blue  <= w.dst_blue;
        do @(posedge clk); while (texel_bus.ready !== 1'b1);
        pending_pixels.push_back(blend_pixel(w));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        texel_bus.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    function automatic texel_word_t make_texel(input int tr, input int tg, input int tb,
                                               input int ta, input int dr, input int dg,
                                               input int db);
        texel_word_t w;
        w.tex_red   = CH_W'(tr);
        w.tex_green = CH_W'(tg);
        w.tex_blue  = CH_W'(tb);
        w.tex_alpha = CH_W'(ta);
        w.dst_red   = CH_W'(dr);
        w.dst_green = CH_W'(dg);
        w.dst_blue  = CH_W'(db);
        return w;
    endfunction

    function automatic logic [CH_W-1:0] random_byte();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic texel_word_t random_texel();
        texel_word_t w;
        w.tex_red   = random_byte();
        w.tex_green = random_byte();
        w.tex_blue  = random_byte();
        case ($urandom_range(0, 3))
            0:       w.tex_alpha = csb_pkg::ALPHA_CLEAR;
            1:       w.tex_alpha = csb_pkg::ALPHA_OPAQUE;
            default: w.tex_alpha = CH_W'($urandom_range(0, 255));
        endcase
        w.dst_red   = random_byte();
        w.dst_green = random_byte();
        w.dst_blue  = random_byte();
        return w;
    endfunction

    function automatic logic [DATA_W-1:0] reg_word(input int v);
        logic [DATA_W-DIM_W-1:0] junk;
        junk = $urandom_range(0, 3) == 0 ? (DATA_W-DIM_W)'($urandom) : '0;
        return {junk, DIM_W'(v)};
    endfunction

    function automatic int pick_dim(input int typical_max);
        case ($urandom_range(0, 11))
            0:       return 0;
            1:       return $urandom_range(MAX_DIM + 1, 8191);
            2:       return MAX_DIM;
            3:       return 1;
            default: return $urandom_range(1, typical_max);
        endcase
    endfunction

    function automatic int pick_pos();
        case ($urandom_range(0, 9))
            0:       return -4096;
            1:       return 4095;
            2:       return $urandom_range(0, 8191);
            default: return $urandom_range(0, 60) - 20;
        endcase
    endfunction

    task automatic test_defaults();
        send_texel(make_texel(255, 255, 255, 255, 0, 0, 0));
        send_texel(make_texel(0, 0, 0, 0, 255, 255, 255));
        send_texel(make_texel(255, 255, 255, 1, 0, 0, 0));
        send_texel(make_texel(0, 0, 0, 254, 255, 255, 255));
        send_texel(make_texel(200, 100, 50, 128, 10, 20, 30));
        send_texel(make_texel(0, 0, 0, 255, 255, 255, 255));
        wait_idle();
    endtask

    task automatic test_extremes();
        write_reg(csb_pkg::REG_SCREEN_WIDTH, reg_word(8191));
        write_reg(csb_pkg::REG_SCREEN_HEIGHT, reg_word(MAX_DIM));
        write_reg(csb_pkg::REG_SPRITE_WIDTH, reg_word(0));
        write_reg(csb_pkg::REG_SPRITE_HEIGHT, reg_word(0));
        write_reg(csb_pkg::REG_POS_X, reg_word(4095));
        write_reg(csb_pkg::REG_POS_Y, reg_word(4095));
        send_texel(make_texel(17, 34, 51, 255, 1, 2, 3));
        send_texel(make_texel(255, 0, 255, 100, 0, 255, 0));
        wait_idle();
        write_reg(csb_pkg::REG_POS_X, reg_word(-4096));
        send_texel(make_texel(9, 9, 9, 255, 9, 9, 9));
        wait_idle();
    endtask

    task automatic test_clipping();
        int n;
        write_reg(csb_pkg::REG_SCREEN_WIDTH, reg_word(1));
        write_reg(csb_pkg::REG_SCREEN_HEIGHT, reg_word(1));
        write_reg(csb_pkg::REG_SPRITE_WIDTH, reg_word(3));
        write_reg(csb_pkg::REG_SPRITE_HEIGHT, reg_word(3));
        write_reg(csb_pkg::REG_POS_X, reg_word(-1));
        write_reg(csb_pkg::REG_POS_Y, reg_word(-1));
        for (n = 0; n < 9; n++)
        begin
            send_texel(make_texel(n * 28, 255 - n, n, n % 2 ? 255 : 77, 3, 5, 7));
        end
        wait_idle();
    endtask

    task automatic test_shrink();
        int n;
        write_reg(csb_pkg::REG_SCREEN_WIDTH, reg_word(16));
        write_reg(csb_pkg::REG_SCREEN_HEIGHT, reg_word(16));
        write_reg(csb_pkg::REG_SPRITE_WIDTH, reg_word(4));
        write_reg(csb_pkg::REG_SPRITE_HEIGHT, reg_word(3));
        write_reg(csb_pkg::REG_POS_X, reg_word(2));
        write_reg(csb_pkg::REG_POS_Y, reg_word(3));
        for (n = 0; n < 6; n++)
        begin
            send_texel(make_texel(n, n + 1, n + 2, 255, 0, 0, 0));
        end
        wait_idle();
        write_reg(UNMAPPED_IDX_A, $urandom);
        write_reg(UNMAPPED_IDX_B, $urandom);
        write_reg(csb_pkg::REG_SPRITE_WIDTH, reg_word(2));
        write_reg(csb_pkg::REG_SPRITE_HEIGHT, reg_word(1));
        send_texel(make_texel(40, 50, 60, 90, 200, 210, 220));
        send_texel(make_texel(70, 80, 90, 255, 1, 1, 1));
        wait_idle();
    endtask

    task automatic test_random();
        int phase;
        int n;
        for (phase = 0; phase < 14; phase++)
        begin
            calm = phase >= 12;
            write_reg(csb_pkg::REG_SCREEN_WIDTH, reg_word(pick_dim(48)));
            write_reg(csb_pkg::REG_SCREEN_HEIGHT, reg_word(pick_dim(48)));
            write_reg(csb_pkg::REG_SPRITE_WIDTH, reg_word(pick_dim(12)));
            write_reg(csb_pkg::REG_SPRITE_HEIGHT, reg_word(pick_dim(12)));
            write_reg(csb_pkg::REG_POS_X, reg_word(pick_pos()));
            write_reg(csb_pkg::REG_POS_Y, reg_word(pick_pos()));
            if ($urandom_range(0, 4) == 0)
            begin
                write_reg($urandom_range(UNMAPPED_IDX_A, UNMAPPED_IDX_B), $urandom);
            end
            n = $urandom_range(45, 65);
            repeat (n)
            begin
                send_texel(random_texel());
            end
            wait_idle();
        end
    endtask

    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        texel_bus.valid     = 1'b0;
        texel_bus.tex_red   = '0;
        texel_bus.tex_green = '0;
        texel_bus.tex_blue  = '0;
        texel_bus.tex_alpha = '0;
        texel_bus.dst_red   = '0;
        texel_bus.dst_green = '0;
        texel_bus.dst_blue  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_defaults();
        test_extremes();
        test_clipping();
        test_shrink();
        test_random();

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_pixels.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/csb_pkg.sv
src/csb_if.sv
src/clipped_alpha_sprite_blit_core.sv
dv/clipped_alpha_sprite_blit_core_tb.sv
